[design/bbfh_pkg.sv]
// Shared types and codes for the back/forward history block.
package bbfh_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int REV_W    = 64;

  localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BACK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FORWARD = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Control that travels with a word from the state update to the output stage
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                rd;
  } resp_ctl_t;

endpackage

[design/bbfh_in_if.sv]
// Request channel: command words into the history block.
interface bbfh_in_if #(
  parameter int LOC_W = 32
);
  logic                        valid;
  logic                        ready;
  logic [bbfh_pkg::CMD_W-1:0]  command;
  logic [LOC_W-1:0]            location;
  logic                        location_empty;

  modport source (output valid, command, location, location_empty, input ready);
  modport sink   (input valid, command, location, location_empty, output ready);
endinterface

[design/bbfh_out_if.sv]
// Response channel: result words out of the history block.
interface bbfh_out_if #(
  parameter int LOC_W = 32,
  parameter int CNT_W = 7
);
  logic                           valid;
  logic                           ready;
  logic [bbfh_pkg::STATUS_W-1:0]  status;
  logic [LOC_W-1:0]               location_out;
  logic [bbfh_pkg::REV_W-1:0]     revision_out;
  logic [CNT_W-1:0]               entry_count;
  logic [CNT_W-1:0]               cursor_position;

  modport source (output valid, status, location_out, revision_out, entry_count,
                  cursor_position, input ready);
  modport sink   (input valid, status, location_out, revision_out, entry_count,
                  cursor_position, output ready);
endinterface

[design/bbfh_store.sv]
// Entry store: one write port, one read port with registered read data.
module bbfh_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 96
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold the read word until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/bbfh_state.sv]
// Cursor, count, ring base and revision update with store address generation.
module bbfh_state #(
  parameter int CAPACITY = 64,
  parameter int LOC_W    = 32,
  parameter int AW       = 6,
  parameter int CNT_W    = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [bbfh_pkg::CMD_W-1:0]  command,
  input  logic [LOC_W-1:0]            location,
  input  logic                        location_empty,
  output logic                        we,
  output logic [AW-1:0]               waddr,
  output logic [bbfh_pkg::REV_W+LOC_W-1:0] wdata,
  output logic                        re,
  output logic [AW-1:0]               raddr,
  output bbfh_pkg::resp_ctl_t         ctl,
  output logic [CNT_W-1:0]            count_next,
  output logic [CNT_W-1:0]            cursor_next
);
  import bbfh_pkg::*;

  localparam int SW = CNT_W + 1;

  logic [AW-1:0]    base;
  logic [AW-1:0]    base_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] cursor;
  logic [REV_W-1:0] revision;
  logic [REV_W-1:0] revision_next;
  logic             full;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b,
                                          input logic [CNT_W-1:0] l);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(l);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  assign full = (cursor == CNT_W'(CAPACITY));

  always_comb begin
    we            = 1'b0;
    re            = 1'b0;
    waddr         = phys(base, cursor);
    raddr         = phys(base, cursor);
    wdata         = {revision + REV_W'(1), location};
    ctl.status    = STATUS_OK;
    ctl.rd        = 1'b0;
    base_next     = base;
    count_next    = count;
    cursor_next   = cursor;
    revision_next = revision;
    unique case (command)
      CMD_PUSH: begin
        if (location_empty) begin
          ctl.status = STATUS_INVALID;
        end else begin
          // Forward entries drop by taking the cursor as the new count
          we            = 1'b1;
          revision_next = revision + REV_W'(1);
          if (full) begin
            // Evict the oldest: its slot takes the new entry
            waddr       = base;
            base_next   = (base == AW'(CAPACITY - 1)) ? '0 : base + AW'(1);
            count_next  = CNT_W'(CAPACITY);
            cursor_next = CNT_W'(CAPACITY);
          end else begin
            count_next  = cursor + CNT_W'(1);
            cursor_next = cursor + CNT_W'(1);
          end
        end
      end
      CMD_BACK: begin
        if (cursor <= CNT_W'(1)) begin
          ctl.status = STATUS_NOT_FOUND;
        end else begin
          re          = 1'b1;
          ctl.rd      = 1'b1;
          raddr       = phys(base, cursor - CNT_W'(2));
          cursor_next = cursor - CNT_W'(1);
        end
      end
      CMD_FORWARD: begin
        if (cursor >= count) begin
          ctl.status = STATUS_NOT_FOUND;
        end else begin
          re          = 1'b1;
          ctl.rd      = 1'b1;
          cursor_next = cursor + CNT_W'(1);
        end
      end
      default: begin
        ctl.status = STATUS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      count    <= '0;
      cursor   <= '0;
      revision <= REV_W'(1);
    end else if (accept) begin
      base     <= base_next;
      count    <= count_next;
      cursor   <= cursor_next;
      revision <= revision_next;
    end
  end

  a_cursor_in_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= count)
    else $error("cursor beyond entry count");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_revision_step: assert property (@(posedge clk) disable iff (rst)
    accept && we |=> revision == $past(revision) + REV_W'(1))
    else $error("revision not advanced by a push");

  a_no_read_and_write: assert property (@(posedge clk) disable iff (rst)
    !(we && re))
    else $error("one command both reads and writes the store");

endmodule

[design/bounded_back_forward_history.sv]
// Bounded back/forward history: top level with store, state update and output stage.
//
// The request channel carries a command (push, back, forward), a location word and
// an empty flag; the response channel returns one word per request: status, the
// location and revision read for a back or forward (zero otherwise), and the entry
// count and cursor after the command.
// An accepted request passes the read stage, which lines up with the synchronous
// read of the entry store, and then the output register.
// Throughput: one request per cycle unless the receiver stalls; a push writes its
// entry at acceptance and the read port serves a following back or forward at once.
// Reset (rst, synchronous) empties the history, clears the cursor and ring base and
// sets the revision counter to one; the store contents are left as they are and
// only written entries are ever read.
// When the receiver stalls, the output register holds its word and one more request
// waits in the read stage; request.ready falls once both are full.
module bounded_back_forward_history #(
  parameter int CAPACITY       = 64,
  parameter int LOCATION_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  bbfh_in_if.sink    request,
  bbfh_out_if.source response
);
  import bbfh_pkg::*;

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int DW    = REV_W + LOCATION_WIDTH;

  logic                accept;
  logic                we;
  logic                re;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic [DW-1:0]       wdata;
  logic [DW-1:0]       rdata;
  resp_ctl_t           ctl;
  logic [CNT_W-1:0]    count_next;
  logic [CNT_W-1:0]    cursor_next;

  logic                s1_valid;
  resp_ctl_t           s1_ctl;
  logic [CNT_W-1:0]    s1_count;
  logic [CNT_W-1:0]    s1_cursor;
  logic                out_take;
  logic                s1_adv;

  assign out_take      = !response.valid || response.ready;
  assign s1_adv        = s1_valid && out_take;
  assign request.ready = !s1_valid || s1_adv;
  assign accept        = request.valid && request.ready;

  bbfh_state #(
    .CAPACITY (CAPACITY),
    .LOC_W    (LOCATION_WIDTH),
    .AW       (AW),
    .CNT_W    (CNT_W)
  ) u_state (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .command        (request.command),
    .location       (request.location),
    .location_empty (request.location_empty),
    .we             (we),
    .waddr          (waddr),
    .wdata          (wdata),
    .re             (re),
    .raddr          (raddr),
    .ctl            (ctl),
    .count_next     (count_next),
    .cursor_next    (cursor_next)
  );

  bbfh_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk   (clk),
    .we    (accept && we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept && re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read stage: the store's read word lines up with this register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_ctl    <= ctl;
      s1_count  <= count_next;
      s1_cursor <= cursor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      response.valid <= 1'b0;
    end else if (s1_adv) begin
      response.valid <= 1'b1;
    end else if (response.ready) begin
      response.valid <= 1'b0;
    end
    if (s1_adv) begin
      response.status          <= s1_ctl.status;
      response.location_out    <= s1_ctl.rd ? rdata[LOCATION_WIDTH-1:0] : '0;
      response.revision_out    <= s1_ctl.rd ? rdata[DW-1:LOCATION_WIDTH] : '0;
      response.entry_count     <= s1_count;
      response.cursor_position <= s1_cursor;
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    s1_valid && response.valid && !response.ready |=> s1_valid && $stable(s1_ctl))
    else $error("read stage lost its word while the output stalled");

  a_read_has_status_ok: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_ctl.rd |-> s1_ctl.status == STATUS_OK)
    else $error("store read tagged with an error status");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    accept |=> s1_valid)
    else $error("accepted request missing from the read stage");

endmodule

[bench/bounded_back_forward_history_tb.sv]
// Self-checking testbench for the bounded back/forward history block.
`timescale 1ns / 1ps

module bounded_back_forward_history_tb;
  import bbfh_pkg::*;

  localparam int HIST_DEPTH  = 64;
  localparam int LOC_W       = 32;
  localparam int CNT_W       = 7;
  localparam int STALL_LIMIT = 3000;
  localparam int TAIL_CYCLES = 8;
  localparam int LONG_HOLD   = 200;

  // Command code outside the defined set
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LOC_W-1:0]    location_out;
    logic [REV_W-1:0]    revision_out;
    logic [CNT_W-1:0]    entry_count;
    logic [CNT_W-1:0]    cursor_position;
  } history_word_t;

  logic clk;
  logic rst;

  bbfh_in_if  #(.LOC_W(LOC_W))                req_if ();
  bbfh_out_if #(.LOC_W(LOC_W), .CNT_W(CNT_W)) rsp_if ();

  bounded_back_forward_history #(
    .CAPACITY       (HIST_DEPTH),
    .LOCATION_WIDTH (LOC_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if.sink),
    .response (rsp_if.source)
  );

  // Predicted history state
  logic [LOC_W-1:0] hist_loc [HIST_DEPTH];
  logic [REV_W-1:0] hist_rev [HIST_DEPTH];
  logic [5:0]       hist_base;
  int               hist_count;
  int               hist_cursor;
  logic [REV_W-1:0] hist_revision;

  history_word_t expected_words [$];

  int  fail_count;
  int  words_sent;
  int  words_checked;
  int  push_count;
  int  evict_count;
  int  not_found_count;
  int  invalid_count;
  int  idle_cycles;
  bit  burst_mode;
  int  hold_off;
  int  stall_left;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function automatic history_word_t predict_history(input logic [CMD_W-1:0] cmd,
                                                    input logic [LOC_W-1:0] loc,
                                                    input logic             empty);
    history_word_t w;
    logic [5:0]    slot;
    w = '0;
    w.status = STATUS_OK;
    case (cmd)
      CMD_PUSH: begin
        if (empty) begin
          w.status = STATUS_INVALID;
        end else begin
          // drop forward entries, then evict the oldest if still full
          if (hist_cursor < hist_count) hist_count = hist_cursor;
          if (hist_count >= HIST_DEPTH) begin
            hist_base  = hist_base + 6'd1;
            hist_count = hist_count - 1;
            if (hist_cursor > 0) hist_cursor = hist_cursor - 1;
            evict_count++;
          end
          slot = hist_base + 6'(hist_count);
          hist_revision  = hist_revision + 64'd1;
          hist_loc[slot] = loc;
          hist_rev[slot] = hist_revision;
          hist_count     = hist_count + 1;
          hist_cursor    = hist_count;
          push_count++;
        end
      end
      CMD_BACK: begin
        if (hist_cursor <= 1) begin
          w.status = STATUS_NOT_FOUND;
        end else begin
          hist_cursor    = hist_cursor - 1;
          slot           = hist_base + 6'(hist_cursor - 1);
          w.location_out = hist_loc[slot];
          w.revision_out = hist_rev[slot];
        end
      end
      CMD_FORWARD: begin
        if (hist_cursor >= hist_count) begin
          w.status = STATUS_NOT_FOUND;
        end else begin
          slot           = hist_base + 6'(hist_cursor);
          w.location_out = hist_loc[slot];
          w.revision_out = hist_rev[slot];
          hist_cursor    = hist_cursor + 1;
        end
      end
      default: w.status = STATUS_INVALID;
    endcase
    if (w.status == STATUS_INVALID) invalid_count++;
    if (w.status == STATUS_NOT_FOUND) not_found_count++;
    w.entry_count     = CNT_W'(hist_count);
    w.cursor_position = CNT_W'(hist_cursor);
    return w;
  endfunction

  // Offer one word, hold it until taken, then predict its result
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [LOC_W-1:0] loc,
                           input logic empty);
    int gap;
    req_if.valid          <= 1'b1;
    req_if.command        <= cmd;
    req_if.location       <= loc;
    req_if.location_empty <= empty;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    expected_words.push_back(predict_history(cmd, loc, empty));
    words_sent++;
    gap = burst_mode ? 0 : idle_len();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic send_random(input int n, input int push_w, input int back_w);
    int               r;
    logic [CMD_W-1:0] cmd;
    logic             empty;
    for (int i = 0; i < n; i++) begin
      r     = $urandom_range(0, 99);
      empty = 1'b0;
      if (r < 2) begin
        cmd   = CMD_UNKNOWN;
        empty = 1'($urandom_range(0, 1));
      end else if (r < 5) begin
        cmd   = CMD_PUSH;
        empty = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < push_w) cmd = CMD_PUSH;
        else if (r < push_w + back_w) cmd = CMD_BACK;
        else cmd = CMD_FORWARD;
        if (cmd != CMD_PUSH) empty = 1'($urandom_range(0, 1));
      end
      send_word(cmd, $urandom, empty);
    end
  endtask

  task automatic test_directed();
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    send_word(CMD_FORWARD, 32'h0000_0000, 1'b0);
    send_word(CMD_UNKNOWN, 32'h0000_0000, 1'b0);
    send_word(CMD_PUSH,    32'h1234_5678, 1'b1);
    send_word(CMD_PUSH,    32'h0000_0000, 1'b0);
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    send_word(CMD_FORWARD, 32'h0000_0000, 1'b0);
    send_word(CMD_PUSH,    32'hFFFF_FFFF, 1'b0);
    send_word(CMD_PUSH,    32'hA5A5_A5A5, 1'b0);
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    send_word(CMD_FORWARD, 32'h0000_0000, 1'b0);
    // push from the middle discards the entry ahead
    send_word(CMD_PUSH,    32'h5A5A_5A5A, 1'b0);
    send_word(CMD_FORWARD, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_BACK,    32'hFFFF_FFFF, 1'b0);
    send_word(CMD_UNKNOWN, 32'hFFFF_FFFF, 1'b1);
    send_word(CMD_PUSH,    32'hFFFF_FFFF, 1'b1);
    send_word(CMD_FORWARD, 32'h0000_0000, 1'b0);
    send_word(CMD_BACK,    32'h0000_0000, 1'b1);
    send_word(CMD_BACK,    32'h0000_0000, 1'b0);
    wait_drained();
  endtask

  // Fill past capacity so that the oldest entries are evicted
  task automatic test_fill_evict();
    send_random(130, 88, 8);
    burst_mode = 1'b1;
    send_random(40, 92, 4);
    burst_mode = 1'b0;
  endtask

  // Walk the whole history back to the start and forward to the end
  task automatic test_sweep();
    for (int i = 0; i < HIST_DEPTH + 4; i++)
      send_word(CMD_BACK, $urandom, 1'($urandom_range(0, 1)));
    for (int i = 0; i < HIST_DEPTH + 4; i++)
      send_word(CMD_FORWARD, $urandom, 1'($urandom_range(0, 1)));
  endtask

  task automatic test_navigation();
    send_random(150, 15, 45);
    send_random(200, 40, 35);
    send_random(200, 60, 25);
    burst_mode = 1'b1;
    send_random(100, 40, 35);
    burst_mode = 1'b0;
  endtask

  // Hold the receiver off while words keep coming so the block fills up
  task automatic test_backpressure();
    hold_off = LONG_HOLD;
    burst_mode = 1'b1;
    send_random(40, 45, 30);
    burst_mode = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_random(60, 50, 30);
    wait_drained();
    send_random(230, 45, 30);
  endtask

  // Receiver: random stalls, plus a long hold-off when asked
  initial begin
    rsp_if.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        rsp_if.ready <= 1'b0;
        hold_off--;
      end else if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (!burst_mode && $urandom_range(0, 99) < 25) begin
        stall_left = idle_len();
        rsp_if.ready <= (stall_left == 0);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    history_word_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: status %0d location %h", rsp_if.status,
               rsp_if.location_out);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.location_out !== want.location_out) begin
          $error("location_out: expected %h, got %h", want.location_out, rsp_if.location_out);
          fail_count++;
        end
        if (rsp_if.revision_out !== want.revision_out) begin
          $error("revision_out: expected %0d, got %0d", want.revision_out, rsp_if.revision_out);
          fail_count++;
        end
        if (rsp_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, rsp_if.entry_count);
          fail_count++;
        end
        if (rsp_if.cursor_position !== want.cursor_position) begin
          $error("cursor_position: expected %0d, got %0d", want.cursor_position,
                 rsp_if.cursor_position);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    fail_count      = 0;
    words_sent      = 0;
    words_checked   = 0;
    push_count      = 0;
    evict_count     = 0;
    not_found_count = 0;
    invalid_count   = 0;
    burst_mode      = 1'b0;
    hold_off        = 0;
    hist_base       = '0;
    hist_count      = 0;
    hist_cursor     = 0;
    hist_revision   = 64'd1;
    rst                   <= 1'b1;
    req_if.valid          <= 1'b0;
    req_if.command        <= CMD_PUSH;
    req_if.location       <= '0;
    req_if.location_empty <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_fill_evict();
    test_sweep();
    test_navigation();
    test_backpressure();
    test_drain_pause();
    wait_drained();

    $display("Sent %0d words and checked %0d results: %0d pushes, %0d evictions,",
             words_sent, words_checked, push_count, evict_count);
    $display("%0d not-found and %0d invalid answers, with stalls on both channels.",
             not_found_count, invalid_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
